FILE: sv/tvsa_pkg.sv
// Package for the tank volume sensor averager: payload and control types,
// conversion constants, the state encoding and the averaging reciprocal table.
// No dependencies.
package tvsa_pkg;

  // Averaging ring
  localparam int AVG_DEPTH = 16;
  localparam int HEAD_W    = $clog2(AVG_DEPTH);
  localparam int LEN_W     = 5;
  localparam logic [LEN_W-1:0] AVG_LEN_MAX = LEN_W'(AVG_DEPTH);

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_LENGTH  = 2'd1;
  localparam logic [15:0]      SAMPLE_INTERVAL_RESET = 16'd50;
  localparam logic [LEN_W-1:0] AVERAGE_LENGTH_RESET  = 5'd0;

  // Volume conversion constants
  localparam logic signed [12:0] MV_LOW     = 13'sd428;
  localparam logic [15:0]        PA_FULL    = 16'd35000;
  localparam logic [10:0]        PA_SPAN    = 11'd1620;
  // floor((2^37 - 1) / 1620)
  localparam logic [26:0]        PA_RECIP   = 27'd84838860;
  localparam int                 PA_SHIFT   = 37;
  localparam int                 AVG_SHIFT  = 25;
  localparam logic [15:0]        VOL_SCALE  = 16'd42514;
  localparam logic [31:0]        VOL_ROUND  = 32'd32768;
  localparam logic signed [16:0] VOL_OFFSET = 17'sd810;
  // A shrunk window divides a total of up to sixteen entries by one
  localparam logic [19:0]        QUOT_MAX   = 20'd568192;
  localparam logic signed [21:0] TOTAL_LIMIT = 22'sd568192;

  typedef struct packed {
    logic signed [15:0] adc_first;
    logic               present_first;
    logic signed [15:0] adc_second;
    logic               present_second;
  } tick_t;

  typedef struct packed {
    logic signed [16:0] volume_value;
    logic               rising;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MV,
    ST_PA_MUL,
    ST_CV_Q0,
    ST_CV_QD,
    ST_CV_FIX,
    ST_VOL_MUL,
    ST_VOL_RND,
    ST_AVG,
    ST_AV_LOAD,
    ST_AV_Q0,
    ST_AV_QD,
    ST_AV_FIX,
    ST_COMMIT,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic start_sample;
    logic sel_second;
    logic mv;
    logic pa_mul;
    logic div_load_avg;
    logic div_q0;
    logic div_qd;
    logic div_fix;
    logic vol_mul;
    logic vol_rnd;
    logic ring_update;
    logic commit;
    logic commit_avg;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic avg_off;
    logic cur_eq_prev;
    logic out_free;
  } status_t;

  // floor((2^25 - 1) / len) for window lengths 1 to 16
  function automatic logic [26:0] avg_recip(input logic [LEN_W-1:0] len);
    logic [26:0] r;
    unique case (len)
      5'd1:    r = 27'd33554431;
      5'd2:    r = 27'd16777215;
      5'd3:    r = 27'd11184810;
      5'd4:    r = 27'd8388607;
      5'd5:    r = 27'd6710886;
      5'd6:    r = 27'd5592405;
      5'd7:    r = 27'd4793490;
      5'd8:    r = 27'd4194303;
      5'd9:    r = 27'd3728270;
      5'd10:   r = 27'd3355443;
      5'd11:   r = 27'd3050402;
      5'd12:   r = 27'd2796202;
      5'd13:   r = 27'd2581110;
      5'd14:   r = 27'd2396745;
      5'd15:   r = 27'd2236962;
      5'd16:   r = 27'd2097151;
      default: r = 27'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/tank_volume_sensor_averager.sv
// Top level of the tank volume sensor averager.
// Joins tvsa_controller and tvsa_datapath; types from tvsa_pkg.
//
// Usage:
//   tick channel (tick_valid/tick_stall/tick_data): one request per timer
//   tick with two ADC codes and their device-present flags. A request is
//   taken at an edge with tick_valid high and tick_stall low.
//   result channel (result_valid/result_stall/result_data): zero or one
//   request per tick carrying volume_value and rising.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register 0 is
//   sample_interval, register 1 is average_length; cfg_ready is always high.
//   Write only while the block is idle.
// Timing: the controller handles one tick at a time. A tick that does not
//   reach the sample interval is checked and dropped. A sample runs one
//   conversion pass, plus the window average with averaging on; a changed
//   sample adds a second conversion pass, after which the result is registered.
//   Each pass runs through one shared reciprocal-multiply divider, used
//   for the pressure scaling and again for the window average.
// Reset (rst, synchronous): clears the counter, history, ring and total,
//   and restores the register defaults.
// A stalled result is held in the output register; the next tick is still
//   taken, and only a further result waits for the register to free.
module tank_volume_sensor_averager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  output logic                              tick_stall,
  input  tvsa_pkg::tick_t                   tick_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output tvsa_pkg::result_t                 result_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tvsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tvsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tvsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  tvsa_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tvsa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .tick_data    (tick_data),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

FILE: sv/tvsa_datapath.sv
// Datapath of the tank volume sensor averager: configuration registers, tick
// counter, volume conversion, reciprocal divider, averaging ring and result register.
// Depends on tvsa_pkg; driven by tvsa_controller through cmd_t.
module tvsa_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tvsa_pkg::tick_t                   tick_data,
  input  tvsa_pkg::cmd_t                    cmd,
  output tvsa_pkg::status_t                 status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tvsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tvsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output tvsa_pkg::result_t                 result_data
);
  import tvsa_pkg::*;

  logic [15:0]        sample_interval;
  logic [LEN_W-1:0]   average_length;
  tick_t              held;
  logic [15:0]        tick_count;
  // Sample history keeps the full average, which a shrunk window can push
  // past the 17-bit result field
  logic signed [21:0] previous_value;
  logic signed [21:0] current_value;
  logic signed [12:0] mv_diff;
  logic [26:0]        div_mag;
  logic               div_neg;
  logic               div_avg;
  logic [10:0]        div_d;
  logic [26:0]        div_recip;
  logic [19:0]        div_q0;
  logic [26:0]        div_qd;
  logic [19:0]        div_quot;
  logic [31:0]        vol_prod;
  logic               vol_neg;
  logic signed [16:0] volume;
  logic signed [16:0] average_ring [AVG_DEPTH];
  logic [HEAD_W-1:0]  ring_head;
  logic signed [21:0] running_total;
  logic               result_valid_r;
  result_t            result_r;

  logic signed [15:0] code;
  logic               present;
  logic signed [16:0] code_adj;
  logic signed [12:0] mv;
  logic [12:0]        diff_abs;
  logic [27:0]        pa_prod;
  logic [21:0]        total_abs;
  logic [LEN_W-1:0]   len_eff;
  logic [53:0]        q0_prod;
  logic [19:0]        q0_next;
  logic [30:0]        qd_prod;
  logic [26:0]        div_rem;
  logic [19:0]        quot_next;
  logic signed [21:0] div_signed;
  logic [31:0]        vol_prod_next;
  logic [31:0]        vol_round;
  logic [15:0]        vol_mag;
  logic signed [16:0] vol_signed;
  logic signed [16:0] volume_next;
  logic signed [16:0] ring_old;
  logic signed [21:0] total_next;
  logic [LEN_W-1:0]   head_inc;
  logic [HEAD_W-1:0]  head_next;

  assign cfg_ready = 1'b1;

  // Pick the reading for this pass and truncate code / 16 toward zero
  assign code     = cmd.sel_second ? held.adc_second : held.adc_first;
  assign present  = cmd.sel_second ? held.present_second : held.present_first;
  assign code_adj = {code[15], code} + {13'd0, {4{code[15]}}};
  assign mv       = code_adj[16:4];

  // Pressure numerator as sign and magnitude
  assign diff_abs = mv_diff[12] ? 13'(-mv_diff) : 13'(mv_diff);
  assign pa_prod  = {16'd0, diff_abs[11:0]} * {12'd0, PA_FULL};

  assign total_abs = running_total[21] ? 22'(-running_total) : 22'(running_total);
  assign len_eff   = (average_length > AVG_LEN_MAX) ? AVG_LEN_MAX : average_length;

  // Reciprocal divide: estimate, back-multiply, correct by one
  assign q0_prod   = {27'd0, div_mag} * {27'd0, div_recip};
  assign q0_next   = div_avg ? q0_prod[AVG_SHIFT+19:AVG_SHIFT]
                             : {3'd0, q0_prod[53:PA_SHIFT]};
  assign qd_prod   = {11'd0, div_q0} * {20'd0, div_d};
  assign div_rem   = div_mag - div_qd;
  assign quot_next = (div_rem >= {16'd0, div_d}) ? div_q0 + 20'd1 : div_q0;
  assign div_signed = div_neg ? -$signed({2'b0, div_quot}) : $signed({2'b0, div_quot});

  // Scale to volume, round halves away from zero, remove offset
  assign vol_prod_next = {12'd0, div_quot} * {16'd0, VOL_SCALE};
  assign vol_round     = vol_prod + VOL_ROUND;
  assign vol_mag       = vol_round[31:16];
  assign vol_signed    = vol_neg ? -$signed({1'b0, vol_mag}) : $signed({1'b0, vol_mag});
  assign volume_next   = present ? vol_signed - VOL_OFFSET : 17'sd0;

  // Ring update terms
  assign ring_old   = average_ring[ring_head];
  assign total_next = running_total + {{5{volume[16]}}, volume}
                                    - {{5{ring_old[16]}}, ring_old};
  assign head_inc   = {1'b0, ring_head} + LEN_W'(1);
  assign head_next  = (head_inc >= len_eff) ? '0 : head_inc[HEAD_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= SAMPLE_INTERVAL_RESET;
      average_length  <= AVERAGE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SAMPLE_INTERVAL) begin
        sample_interval <= cfg_data[15:0];
      end else if (cfg_index == REG_AVERAGE_LENGTH) begin
        average_length <= cfg_data[LEN_W-1:0];
      end
    end
  end

  // Tick counter and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      previous_value <= '0;
      current_value  <= '0;
    end else begin
      if (cmd.load_in) begin
        tick_count <= tick_count + 16'd1;
      end else if (cmd.start_sample) begin
        tick_count     <= '0;
        previous_value <= current_value;
      end
      if (cmd.commit) begin
        current_value <= cmd.commit_avg ? div_signed : {{5{volume[16]}}, volume};
      end
    end
  end

  // Averaging ring and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        average_ring[i] <= '0;
      end
      ring_head     <= '0;
      running_total <= '0;
    end else if (cmd.ring_update) begin
      average_ring[ring_head] <= volume;
      ring_head               <= head_next;
      running_total           <= total_next;
    end
  end

  // Working registers of the conversion and divide steps
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      held <= tick_data;
    end
    if (cmd.mv) begin
      mv_diff <= mv - MV_LOW;
    end
    if (cmd.pa_mul) begin
      div_mag   <= pa_prod[26:0];
      div_neg   <= mv_diff[12];
      div_avg   <= 1'b0;
      div_d     <= PA_SPAN;
      div_recip <= PA_RECIP;
    end else if (cmd.div_load_avg) begin
      div_mag   <= {5'd0, total_abs};
      div_neg   <= running_total[21];
      div_avg   <= 1'b1;
      div_d     <= {6'd0, len_eff};
      div_recip <= avg_recip(len_eff);
    end
    if (cmd.div_q0) begin
      div_q0 <= q0_next;
    end
    if (cmd.div_qd) begin
      div_qd <= qd_prod[26:0];
    end
    if (cmd.div_fix) begin
      div_quot <= quot_next;
    end
    if (cmd.vol_mul) begin
      vol_prod <= vol_prod_next;
      vol_neg  <= div_neg;
    end
    if (cmd.vol_rnd) begin
      volume <= volume_next;
    end
  end

  // Result register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      result_valid_r <= 1'b1;
    end else if (!result_stall) begin
      result_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_r.volume_value <= current_value[16:0];
      result_r.rising       <= current_value > previous_value;
    end
  end

  assign result_valid = result_valid_r;
  assign result_data  = result_r;

  assign status.due         = tick_count >= sample_interval;
  assign status.avg_off     = len_eff == '0;
  assign status.cur_eq_prev = current_value == previous_value;
  assign status.out_free    = !result_valid_r || !result_stall;

  // The reciprocal estimate is never more than one below the true quotient
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_fix |-> (div_rem < {15'd0, div_d, 1'b0}))
    else $error("divider remainder out of correction range");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_fix |=> (div_quot <= QUOT_MAX))
    else $error("divider quotient beyond conversion range");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_update |=> ((running_total <= TOTAL_LIMIT) && (running_total >= -TOTAL_LIMIT)))
    else $error("running total outside the sum of ring entries");

endmodule

FILE: sv/tvsa_controller.sv
// Controller of the tank volume sensor averager: sequences the tick check,
// the first and any second conversion pass, averaging and result delivery.
// Depends on tvsa_pkg; commands tvsa_datapath through cmd_t.
module tvsa_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tvsa_pkg::status_t status,
  output tvsa_pkg::cmd_t    cmd
);
  import tvsa_pkg::*;

  state_t state;
  state_t state_next;
  logic   second;
  logic   second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // Next state
  always_comb begin
    state_next  = state;
    second_next = second;
    unique case (state)
      ST_IDLE: begin
        if (tick_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.due) begin
          state_next  = ST_MV;
          second_next = 1'b0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MV:      state_next = ST_PA_MUL;
      ST_PA_MUL:  state_next = ST_CV_Q0;
      ST_CV_Q0:   state_next = ST_CV_QD;
      ST_CV_QD:   state_next = ST_CV_FIX;
      ST_CV_FIX:  state_next = ST_VOL_MUL;
      ST_VOL_MUL: state_next = ST_VOL_RND;
      ST_VOL_RND: state_next = ST_AVG;
      ST_AVG: begin
        state_next = status.avg_off ? ST_DECIDE : ST_AV_LOAD;
      end
      ST_AV_LOAD: state_next = ST_AV_Q0;
      ST_AV_Q0:   state_next = ST_AV_QD;
      ST_AV_QD:   state_next = ST_AV_FIX;
      ST_AV_FIX:  state_next = ST_COMMIT;
      ST_COMMIT:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (second) begin
          state_next = ST_EMIT;
        end else if (status.cur_eq_prev) begin
          state_next = ST_IDLE;
        end else begin
          state_next  = ST_MV;
          second_next = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.sel_second = second;
    tick_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        tick_stall  = 1'b0;
        cmd.load_in = tick_valid;
      end
      ST_CHECK:   cmd.start_sample = status.due;
      ST_MV:      cmd.mv = 1'b1;
      ST_PA_MUL:  cmd.pa_mul = 1'b1;
      ST_CV_Q0:   cmd.div_q0 = 1'b1;
      ST_CV_QD:   cmd.div_qd = 1'b1;
      ST_CV_FIX:  cmd.div_fix = 1'b1;
      ST_VOL_MUL: cmd.vol_mul = 1'b1;
      ST_VOL_RND: cmd.vol_rnd = 1'b1;
      ST_AVG: begin
        cmd.commit      = status.avg_off;
        cmd.ring_update = !status.avg_off;
      end
      ST_AV_LOAD: cmd.div_load_avg = 1'b1;
      ST_AV_Q0:   cmd.div_q0 = 1'b1;
      ST_AV_QD:   cmd.div_qd = 1'b1;
      ST_AV_FIX:  cmd.div_fix = 1'b1;
      ST_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.commit_avg = 1'b1;
      end
      ST_DECIDE:  cmd = cmd;
      ST_EMIT:    cmd.emit = status.out_free;
      default:    cmd = cmd;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result loaded while the output register is occupied");

  a_check_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ($past(state) == ST_IDLE))
    else $error("tick check entered without an accepted request");

  a_second_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> second)
    else $error("result emitted before the second conversion");

endmodule

FILE: sim/tb_tank_volume_sensor_averager.sv
// Self-checking testbench for tank_volume_sensor_averager: a clocked driver and
// monitor, an in-bench volume and window-average predictor, random idling.
// Depends on tvsa_pkg and the tank_volume_sensor_averager RTL.
module tb_tank_volume_sensor_averager;
  import tvsa_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int MAX_REPORTS      = 10;
  localparam int RANDOM_PHASES    = 9;

  // Conversion constants of the sensor chain
  localparam int MV_FLOOR     = 428;
  localparam int MV_SPAN      = 1620;
  localparam int PA_RANGE     = 35000;
  localparam longint VOL_Q16  = 42514;
  localparam longint HALF_Q16 = 32768;
  localparam int VOL_BIAS     = 810;
  localparam int WINDOW_MAX   = 16;

  // Register indexes the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic tick_valid = 1'b0;
  logic tick_stall;
  tick_t tick_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tank_volume_sensor_averager dut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick_data(tick_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register copies and sampler state held by the predictor
  logic [15:0] interval_reg = SAMPLE_INTERVAL_RESET;
  logic [4:0] window_reg = AVERAGE_LENGTH_RESET;
  logic [15:0] tick_total = '0;
  int last_volume = 0;
  int latest_volume = 0;
  int window_ring [WINDOW_MAX];
  int unsigned window_head = 0;
  int window_sum = 0;

  tick_t ticks_to_send [$];
  result_t expected_volumes [$];
  tick_t recent_tick = '0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_requested = 1'b0;
  logic receiver_hold = 1'b0;
  int unsigned tick_gap = 0;
  int unsigned rx_wait = 0;
  int mismatches = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    foreach (window_ring[i]) window_ring[i] = 0;
  end

  // Code to millivolts to pascals to centilitres, rounded half away from zero
  function automatic int volume_of(logic signed [15:0] code, logic present);
    int mv;
    int pa;
    longint prod;
    longint mag;
    longint r;
    if (!present) return 0;
    mv = int'(code) / 16;
    pa = (mv - MV_FLOOR) * PA_RANGE / MV_SPAN;
    prod = longint'(pa) * VOL_Q16;
    mag = prod < 0 ? -prod : prod;
    r = (mag + HALF_Q16) >>> 16;
    if (prod < 0) r = -r;
    return int'(r) - VOL_BIAS;
  endfunction

  // Push a value through the moving-average ring and return the mean
  function automatic int window_average(int v);
    int unsigned len;
    int unsigned h;
    len = window_reg > WINDOW_MAX ? WINDOW_MAX : window_reg;
    if (len == 0) return v;
    h = window_head % WINDOW_MAX;
    window_sum = window_sum + v - window_ring[h];
    window_ring[h] = v;
    window_head = (h + 1 >= len) ? 0 : h + 1;
    return window_sum / int'(len);
  endfunction

  // Advance the tick counter and queue the volume a changed sample reports
  function automatic void sample_tick(tick_t t);
    result_t r;
    tick_total = tick_total + 16'd1;
    if (tick_total < interval_reg) return;
    tick_total = '0;
    last_volume = latest_volume;
    latest_volume = window_average(volume_of(t.adc_first, t.present_first));
    if (latest_volume == last_volume) return;
    latest_volume = window_average(volume_of(t.adc_second, t.present_second));
    r.volume_value = 17'(latest_volume);
    r.rising = latest_volume > last_volume;
    expected_volumes.push_back(r);
  endfunction

  function automatic tick_t make_tick(logic signed [15:0] first, logic pf,
                                      logic signed [15:0] second, logic ps);
    tick_t t;
    t.adc_first = first;
    t.present_first = pf;
    t.adc_second = second;
    t.present_second = ps;
    return t;
  endfunction

  // Mostly codes inside the sensor span, some anywhere, some at the rails
  function automatic logic signed [15:0] random_code();
    logic signed [15:0] c;
    case ($urandom_range(0, 7))
      0, 1: c = 16'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: c = 16'sh8000;
          1: c = 16'sh7FFF;
          2: c = 16'sh0000;
          3: c = 16'shFFFF;
          default: c = 16'sd6848;
        endcase
      end
      default: c = 16'($urandom_range(6848, 32767));
    endcase
    return c;
  endfunction

  // Random request; now and then repeat the last resend reading to hit no-change
  function automatic tick_t random_tick();
    tick_t t;
    t = make_tick(random_code(), $urandom_range(0, 7) != 0,
                  random_code(), $urandom_range(0, 7) != 0);
    if ($urandom_range(0, 5) == 0) begin
      t.adc_first = recent_tick.adc_second;
      t.present_first = recent_tick.present_second;
    end
    recent_tick = t;
    return t;
  endfunction

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SAMPLE_INTERVAL) interval_reg = value;
    else if (idx == REG_AVERAGE_LENGTH) window_reg = value[4:0];
  endtask

  task automatic configure(input logic [15:0] interval, input logic [15:0] window);
    write_register(REG_SAMPLE_INTERVAL, interval);
    write_register(REG_AVERAGE_LENGTH, window);
    @(negedge clk);
  endtask

  // Wait for every request to go in, every result to come out, then settle
  task automatic drain();
    do @(negedge clk); while (ticks_to_send.size() != 0 || tick_valid);
    while (expected_volumes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: present queued requests, predict each one the block takes
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      tick_gap <= 0;
    end else begin
      if (tick_valid && !tick_stall) sample_tick(tick_data);
      if (!(tick_valid && tick_stall)) begin
        if (tick_gap != 0) begin
          tick_gap <= tick_gap - 1;
          tick_valid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          tick_data <= ticks_to_send.pop_front();
          tick_valid <= 1'b1;
          tick_gap <= tx_idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result, then stall the next one a drawn while
  always @(posedge clk) begin : monitor
    result_t want;
    int unsigned draw;
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait <= 0;
    end else if (result_valid && !result_stall) begin
      if (expected_volumes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: volume %0d rising %0b",
                   result_data.volume_value, result_data.rising);
        mismatches++;
      end else begin
        want = expected_volumes.pop_front();
        if (result_data.volume_value !== want.volume_value ||
            result_data.rising !== want.rising) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected volume %0d rising %0b, got volume %0d rising %0b",
                     want.volume_value, want.rising,
                     result_data.volume_value, result_data.rising);
          mismatches++;
        end
      end
      draw = rx_idle_on ? $urandom_range(0, 15) : 0;
      rx_wait <= draw;
      result_stall <= receiver_hold || draw != 0;
    end else if (result_valid && rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      result_stall <= receiver_hold || rx_wait > 1;
    end else begin
      result_stall <= receiver_hold || rx_wait != 0;
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin : long_hold
    wait (hold_requested);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin : stimulus
    logic [15:0] interval;
    logic [4:0] len;
    int count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Interval zero samples every tick: rails, span ends, absent devices, no change
    configure(16'd0, 16'd0);
    ticks_to_send.push_back(make_tick(16'sd6848, 1'b1, 16'sh7FFF, 1'b1));
    ticks_to_send.push_back(make_tick(16'sh7FFF, 1'b1, 16'sh8000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sh8000, 1'b1, 16'sh0000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd15, 1'b1, -16'sd15, 1'b1));
    ticks_to_send.push_back(make_tick(-16'sd15, 1'b1, 16'sd20000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd3000, 1'b0, 16'sd20000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd3000, 1'b0, 16'sd9000, 1'b0));
    ticks_to_send.push_back(make_tick(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b0));
    ticks_to_send.push_back(make_tick(16'shFFFF, 1'b1, 16'sh7FF0, 1'b1));
    ticks_to_send.push_back(make_tick(16'sh0010, 1'b1, 16'shFFF0, 1'b1));
    drain();

    // Window beyond the ring depth saturates; spare register indexes are ignored
    write_register(REG_SPARE_A, 16'hFFFF);
    write_register(REG_SPARE_B, 16'h0001);
    configure(16'd1, 16'h001F);
    ticks_to_send.push_back(make_tick(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1));
    ticks_to_send.push_back(make_tick(16'sh8000, 1'b1, 16'sh8000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd12000, 1'b1, 16'sd30000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd6848, 1'b1, 16'sd6848, 1'b0));
    ticks_to_send.push_back(make_tick(16'sd25000, 1'b1, 16'sh8000, 1'b1));
    drain();

    // Window of three, then shrunk to two with the head possibly past the end
    configure(16'd1, 16'd3);
    ticks_to_send.push_back(make_tick(16'sd10000, 1'b1, 16'sd20000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd30000, 1'b1, 16'sd8000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd16000, 1'b1, 16'sd32000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd7000, 1'b1, 16'sd24000, 1'b1));
    drain();
    configure(16'd1, 16'd2);
    ticks_to_send.push_back(make_tick(16'sd28000, 1'b1, 16'sd9000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sd11000, 1'b1, 16'sd31000, 1'b1));
    ticks_to_send.push_back(make_tick(16'sh8000, 1'b0, 16'sd18000, 1'b1));
    drain();

    // Back-pressure: receiver holds off while the sender keeps offering
    configure(16'd1, 16'd0);
    hold_requested = 1'b1;
    for (int i = 0; i < 40; i++) ticks_to_send.push_back(random_tick());
    drain();

    // Random phases over a spread of register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_idle_on = (p % 3) != 0;
      rx_idle_on = (p % 2) == 0;
      count = 50;
      case (p)
        0: begin
          interval = 16'd65535;
          count = 20;
        end
        1: interval = SAMPLE_INTERVAL_RESET;
        2: interval = 16'd0;
        default: interval = 16'($urandom_range(1, 4));
      endcase
      case (p)
        2: len = 5'd16;
        4: len = 5'd31;
        5: len = 5'd1;
        6: len = 5'd0;
        default: len = 5'($urandom_range(0, 16));
      endcase
      configure(interval, {11'($urandom), len});
      for (int i = 0; i < count; i++) ticks_to_send.push_back(random_tick());
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/tvsa_pkg.sv
sv/tvsa_datapath.sv
sv/tvsa_controller.sv
sv/tank_volume_sensor_averager.sv
sim/tb_tank_volume_sensor_averager.sv
